// ----- rtl/rsitt_pkg.sv -----
// Shared types and constants for the RSI threshold trader.
`timescale 1ns / 1ps

package rsitt_pkg;

    // Configuration register widths and port shape
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int WIN_W      = 9;
    localparam int LIM_W      = 8;
    localparam int LVL_W      = 14;

    // Result field widths
    localparam int RSI_W   = 14;
    localparam int UNITS_W = 9;
    localparam int CASH_W  = 48;

    // Divider sequencing: 10000 = 5^4 * 2^4, then one quotient bit a step
    localparam int STEP_W      = 4;
    localparam int SCALE_STEPS = 4;
    localparam int SCALE_SHIFT = 4;

    localparam logic [RSI_W-1:0] RSI_MAX = 14'd10000;

    // Register reset values
    localparam logic [WIN_W-1:0] WIN_RESET = 9'd14;
    localparam logic [LIM_W-1:0] LIM_RESET = 8'd5;
    localparam logic [LVL_W-1:0] OB_RESET  = 14'd7000;
    localparam logic [LVL_W-1:0] OS_RESET  = 14'd3000;

    // Cash saturation bounds
    localparam logic signed [CASH_W-1:0] CASH_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [CASH_W-1:0] CASH_MIN = 48'sh8000_0000_0000;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW     = 2'd0,
        REG_LIMIT      = 2'd1,
        REG_OVERBOUGHT = 2'd2,
        REG_OVERSOLD   = 2'd3
    } t_cfg_reg;

    // Trade action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    // Status handed back by the divider
    typedef struct packed {
        logic             done;
        logic [RSI_W-1:0] quo;
        logic             rem_nz;
    } t_div_res;

endpackage

// ----- rtl/rsitt_div.sv -----
// Sequential divider: floor(10000 * gain / total) with remainder flag.
`timescale 1ns / 1ps

module rsitt_div #(
    parameter int TOT_W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TOT_W-1:0]    i_gain,
    input  logic [TOT_W-1:0]    i_total,
    output rsitt_pkg::t_div_res o_res
);
    import rsitt_pkg::*;

    localparam int NW = TOT_W + RSI_W;

    typedef enum logic [1:0] {
        D_IDLE,
        D_SCALE,
        D_DIV
    } t_dstate;

    t_dstate           r_state;
    logic [NW-1:0]     r_rem;
    logic [NW-1:0]     r_dsh;
    logic [RSI_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_done;

    logic [NW-1:0]     n_five;
    logic              n_ge;

    // Times five for scaling, trial compare for division
    assign n_five = (r_rem << 2) + r_rem;
    assign n_ge   = (r_rem >= r_dsh);

    // Scale the gain, then restore one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            // Flag the cycle after the last quotient step
            r_done <= (r_state == D_DIV) && (r_step == STEP_W'(RSI_W - 1));
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_rem   <= NW'(i_gain);
                        r_dsh   <= NW'(i_total) << (RSI_W - 1);
                        r_step  <= '0;
                        r_state <= D_SCALE;
                    end
                end
                D_SCALE: begin
                    if (r_step == STEP_W'(SCALE_STEPS - 1)) begin
                        r_rem   <= n_five << SCALE_SHIFT;
                        r_step  <= '0;
                        r_state <= D_DIV;
                    end else begin
                        r_rem  <= n_five;
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                D_DIV: begin
                    if (n_ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_quo <= {r_quo[RSI_W-2:0], n_ge};
                    r_dsh <= r_dsh >> 1;
                    if (r_step == STEP_W'(RSI_W - 1)) begin
                        r_state <= D_IDLE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quo    = r_quo;
    assign o_res.rem_nz = |r_rem;

endmodule

// ----- rtl/rsi_threshold_trader.sv -----
// RSI threshold trader: difference ring, running totals, divider and trade logic.
// The first tick goes straight to the marked-value product; while the window is filling
// or gain plus loss is zero the divider is skipped; with a valid RSI it runs 4 scaling
// steps and 14 quotient steps. A new item is taken only once the last result is handed
// on and the block is idle again. The ring memory needs no clearing pass.
// Synchronous active-low reset restores register defaults and clears all totals.
`timescale 1ns / 1ps

module rsi_threshold_trader #(
    parameter int MAX_WINDOW = 256,
    parameter int PRICE_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Configuration write port
    input  logic                                    i_cfg_we,
    input  logic [rsitt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rsitt_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Price input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [PRICE_BITS-1:0]                   i_price,
    // Result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [rsitt_pkg::RSI_W-1:0]             o_rsi_hundredths,
    output logic                                    o_rsi_valid,
    output logic [1:0]                              o_action,
    output logic signed [rsitt_pkg::UNITS_W-1:0]    o_held_units,
    output logic signed [rsitt_pkg::CASH_W-1:0]     o_cash_balance,
    output logic signed [rsitt_pkg::CASH_W-1:0]     o_marked_value
);
    import rsitt_pkg::*;

    localparam int DIFF_W = PRICE_BITS + 1;
    localparam int TOT_W  = PRICE_BITS + $clog2(MAX_WINDOW);
    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int EW_W   = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
    localparam int PROD_W = PRICE_BITS + UNITS_W + 1;
    localparam int SUM_W  = ((PROD_W > CASH_W) ? PROD_W : CASH_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_ADD,
        S_CHECK,
        S_DIVIDE,
        S_MULT,
        S_OUT
    } t_state;

    // Configuration
    logic [WIN_W-1:0]           r_win_len;
    logic [LIM_W-1:0]           r_pos_lim;
    logic [LVL_W-1:0]           r_ob_lvl;
    logic [LVL_W-1:0]           r_os_lvl;

    // Window state
    t_state                     r_state;
    logic [PRICE_BITS-1:0]      r_prev;
    logic [PRICE_BITS-1:0]      r_price;
    logic signed [DIFF_W-1:0]   r_diff;
    logic [TOT_W-1:0]           r_gain;
    logic [TOT_W-1:0]           r_loss;
    logic [PTR_W-1:0]           r_ptr;
    logic [PTR_W-1:0]           r_wr_ptr;
    logic [CNT_W-1:0]           r_ticks;
    logic                       r_full;

    // Difference ring
    logic signed [DIFF_W-1:0]   r_ring [MAX_WINDOW];
    logic signed [DIFF_W-1:0]   r_ring_q;

    // Position and per-item results
    logic signed [UNITS_W-1:0]  r_units;
    logic signed [CASH_W-1:0]   r_cash;
    logic signed [PROD_W-1:0]   r_prod;
    logic [RSI_W-1:0]           r_rsi;
    logic                       r_rsi_ok;
    logic [1:0]                 r_action;

    // Output register
    logic                       r_out_valid;
    logic [RSI_W-1:0]           r_out_rsi;
    logic                       r_out_rsi_ok;
    logic [1:0]                 r_out_action;
    logic signed [UNITS_W-1:0]  r_out_units;
    logic signed [CASH_W-1:0]   r_out_cash;
    logic signed [CASH_W-1:0]   r_out_marked;

    // Combinational helpers
    logic [EW_W-1:0]            w_eff;
    logic [CNT_W-1:0]           w_win_p1;
    logic [PTR_W-1:0]           w_ptr;
    logic [EW_W-1:0]            w_ptr_inc;
    logic [PTR_W-1:0]           n_ptr;
    logic                       w_full;
    logic signed [DIFF_W-1:0]   w_old_neg;
    logic [PRICE_BITS-1:0]      w_old_mag;
    logic signed [DIFF_W-1:0]   w_new_neg;
    logic [PRICE_BITS-1:0]      w_new_mag;
    logic [TOT_W-1:0]           w_total;
    logic                       w_rsi_ok;
    logic                       w_div_start;
    t_div_res                   w_div;
    logic                       w_sell_cond;
    logic                       w_buy_cond;
    logic signed [UNITS_W:0]    w_units_x;
    logic signed [UNITS_W:0]    w_lim_x;
    logic                       w_can_sell;
    logic                       w_can_buy;
    logic signed [SUM_W-1:0]    w_cash_x;
    logic signed [SUM_W-1:0]    w_price_x;
    logic signed [CASH_W-1:0]   n_cash_up;
    logic signed [CASH_W-1:0]   n_cash_dn;
    logic signed [CASH_W-1:0]   n_marked;
    logic                       w_out_free;

    function automatic logic signed [CASH_W-1:0] f_clamp(input logic signed [SUM_W-1:0] v);
        logic signed [CASH_W-1:0] res;
        if (v > SUM_W'(CASH_MAX)) begin
            res = CASH_MAX;
        end else if (v < SUM_W'(CASH_MIN)) begin
            res = CASH_MIN;
        end else begin
            res = v[CASH_W-1:0];
        end
        return res;
    endfunction

    // Bound the window length to the ring depth
    always_comb begin
        if (r_win_len == '0) begin
            w_eff = EW_W'(1);
        end else if (32'(r_win_len) > 32'(MAX_WINDOW)) begin
            w_eff = EW_W'(MAX_WINDOW);
        end else begin
            w_eff = EW_W'(r_win_len);
        end
    end

    // Ring pointer, wrap and window-full test
    assign w_win_p1  = CNT_W'(w_eff) + CNT_W'(1);
    assign w_ptr     = (EW_W'(r_ptr) >= w_eff) ? '0 : r_ptr;
    assign w_ptr_inc = EW_W'(w_ptr) + EW_W'(1);
    assign n_ptr     = (w_ptr_inc >= w_eff) ? '0 : PTR_W'(w_ptr_inc);
    assign w_full    = (r_ticks >= w_win_p1);

    // Magnitudes of the leaving and the arriving difference
    assign w_old_neg = -r_ring_q;
    assign w_old_mag = r_ring_q[DIFF_W-1] ? w_old_neg[PRICE_BITS-1:0]
                                          : r_ring_q[PRICE_BITS-1:0];
    assign w_new_neg = -r_diff;
    assign w_new_mag = r_diff[DIFF_W-1] ? w_new_neg[PRICE_BITS-1:0]
                                        : r_diff[PRICE_BITS-1:0];

    // RSI is defined once the window is full and there was some movement
    assign w_total     = r_gain + r_loss;
    assign w_rsi_ok    = (r_ticks >= w_win_p1) && (w_total != '0);
    assign w_div_start = (r_state == S_CHECK) && w_rsi_ok;

    rsitt_div #(
        .TOT_W (TOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_gain  (r_gain),
        .i_total (w_total),
        .o_res   (w_div)
    );

    // Exact threshold tests from quotient and remainder
    assign w_sell_cond = (w_div.quo > r_ob_lvl) || ((w_div.quo == r_ob_lvl) && w_div.rem_nz);
    assign w_buy_cond  = (w_div.quo < r_os_lvl);
    assign w_units_x   = (UNITS_W + 1)'(r_units);
    assign w_lim_x     = $signed({2'b00, r_pos_lim});
    assign w_can_sell  = (w_units_x > -w_lim_x);
    assign w_can_buy   = (w_units_x < w_lim_x);

    // Cash moves and marked value, saturated
    assign w_cash_x  = SUM_W'(r_cash);
    assign w_price_x = $signed(SUM_W'(r_price));
    assign n_cash_up = f_clamp(w_cash_x + w_price_x);
    assign n_cash_dn = f_clamp(w_cash_x - w_price_x);
    assign n_marked  = f_clamp(w_cash_x + SUM_W'(r_prod));

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Ring memory: write the new difference, read the leaving one
    always_ff @(posedge i_clk) begin
        if (r_state == S_REMOVE) begin
            r_ring[r_wr_ptr] <= r_diff;
        end
        r_ring_q <= r_ring[w_ptr];
    end

    // Sequence one item, hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_len   <= WIN_RESET;
            r_pos_lim   <= LIM_RESET;
            r_ob_lvl    <= OB_RESET;
            r_os_lvl    <= OS_RESET;
            r_prev      <= '0;
            r_gain      <= '0;
            r_loss      <= '0;
            r_ptr       <= '0;
            r_ticks     <= '0;
            r_units     <= '0;
            r_cash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_price  <= i_price;
                        r_prev   <= i_price;
                        r_diff   <= $signed({1'b0, i_price}) - $signed({1'b0, r_prev});
                        r_wr_ptr <= w_ptr;
                        r_full   <= w_full;
                        r_rsi    <= '0;
                        r_rsi_ok <= 1'b0;
                        r_action <= ACT_NONE;
                        if (r_ticks == '0) begin
                            // First tick: no difference yet
                            r_ticks <= CNT_W'(1);
                            r_state <= S_MULT;
                        end else begin
                            r_state <= S_REMOVE;
                        end
                    end
                end
                S_REMOVE: begin
                    if (r_full) begin
                        if (!r_ring_q[DIFF_W-1]) begin
                            r_gain <= r_gain - TOT_W'(w_old_mag);
                        end else begin
                            r_loss <= r_loss - TOT_W'(w_old_mag);
                        end
                    end
                    r_ptr <= n_ptr;
                    if (r_ticks < w_win_p1) begin
                        r_ticks <= r_ticks + CNT_W'(1);
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (!r_diff[DIFF_W-1]) begin
                        r_gain <= r_gain + TOT_W'(w_new_mag);
                    end else begin
                        r_loss <= r_loss + TOT_W'(w_new_mag);
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (w_rsi_ok) begin
                        r_rsi_ok <= 1'b1;
                        r_state  <= S_DIVIDE;
                    end else begin
                        r_state <= S_MULT;
                    end
                end
                S_DIVIDE: begin
                    if (w_div.done) begin
                        r_rsi <= w_div.quo;
                        // Selling wins when both levels are crossed
                        if (w_sell_cond && w_can_sell) begin
                            r_action <= ACT_SELL;
                            r_units  <= r_units - UNITS_W'(1);
                            r_cash   <= n_cash_up;
                        end else if (w_buy_cond && w_can_buy) begin
                            r_action <= ACT_BUY;
                            r_units  <= r_units + UNITS_W'(1);
                            r_cash   <= n_cash_dn;
                        end
                        r_state <= S_MULT;
                    end
                end
                S_MULT: begin
                    r_prod  <= r_units * $signed({1'b0, r_price});
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_rsi    <= r_rsi;
                        r_out_rsi_ok <= r_rsi_ok;
                        r_out_action <= r_action;
                        r_out_units  <= r_units;
                        r_out_cash   <= r_cash;
                        r_out_marked <= n_marked;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Raise valid on a new result item, drop it once taken
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Register writes; a new window length restarts the window
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_WINDOW: begin
                        r_win_len <= i_cfg_data[WIN_W-1:0];
                        r_gain    <= '0;
                        r_loss    <= '0;
                        r_ptr     <= '0;
                        if (r_ticks > CNT_W'(1)) begin
                            r_ticks <= CNT_W'(1);
                        end
                    end
                    REG_LIMIT:      r_pos_lim <= i_cfg_data[LIM_W-1:0];
                    REG_OVERBOUGHT: r_ob_lvl  <= i_cfg_data[LVL_W-1:0];
                    REG_OVERSOLD:   r_os_lvl  <= i_cfg_data[LVL_W-1:0];
                    default:        r_ob_lvl  <= r_ob_lvl;
                endcase
            end
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_rsi_hundredths = r_out_rsi;
    assign o_rsi_valid      = r_out_rsi_ok;
    assign o_action         = r_out_action;
    assign o_held_units     = r_out_units;
    assign o_cash_balance   = r_out_cash;
    assign o_marked_value   = r_out_marked;

endmodule

// ----- rtl/rsitt_checker.sv -----
// Port-level checks for the RSI threshold trader, bound to the top level.
`timescale 1ns / 1ps

module rsitt_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic [rsitt_pkg::RSI_W-1:0]          o_rsi_hundredths,
    input logic                                 o_rsi_valid,
    input logic [1:0]                           o_action,
    input logic signed [rsitt_pkg::UNITS_W-1:0] o_held_units,
    input logic signed [rsitt_pkg::CASH_W-1:0]  o_cash_balance,
    input logic signed [rsitt_pkg::CASH_W-1:0]  o_marked_value
);
    import rsitt_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cash_balance)
                                       && $stable(o_marked_value))
        else $error("stalled result changed");

    // Busy after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again in the next cycle");

    // No RSI means no trade and a zero reading
    a_invalid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rsi_valid |-> (o_rsi_hundredths == '0) && (o_action == ACT_NONE))
        else $error("trade or reading without a valid RSI");

    // RSI stays within scale
    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rsi_valid |-> (o_rsi_hundredths <= RSI_MAX))
        else $error("RSI above full scale");

    // Flat position marks at cash
    a_flat_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_held_units == '0) |-> (o_marked_value == o_cash_balance))
        else $error("marked value differs from cash with no position");

endmodule

bind rsi_threshold_trader rsitt_checker u_rsitt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_rsi_hundredths (o_rsi_hundredths),
    .o_rsi_valid      (o_rsi_valid),
    .o_action         (o_action),
    .o_held_units     (o_held_units),
    .o_cash_balance   (o_cash_balance),
    .o_marked_value   (o_marked_value)
);

// ----- verif/rsi_threshold_trader_tb.sv -----
// Self-checking testbench for the RSI threshold trader with a trade predictor.
`timescale 1ns / 1ps

module rsi_threshold_trader_tb;
    import rsitt_pkg::*;

    localparam int WINDOW_CAP      = 256;
    localparam int PRICE_W         = 24;
    localparam int PRICE_MAX       = 2 ** PRICE_W - 1;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int RANDOM_TICKS    = 1950;

    typedef struct {
        logic [RSI_W-1:0]          rsi;
        logic                      rsi_ok;
        logic [1:0]                action;
        logic signed [UNITS_W-1:0] units;
        logic signed [CASH_W-1:0]  cash;
        logic signed [CASH_W-1:0]  marked;
    } t_trade_result;

    // Mirror of the trader state; predicts one result item per accepted price
    class t_trade_scoreboard;
        logic [WIN_W-1:0]        window_len;
        logic [LIM_W-1:0]        pos_limit;
        logic [LVL_W-1:0]        sell_level;
        logic [LVL_W-1:0]        buy_level;
        logic [PRICE_W-1:0]      last_price;
        logic signed [PRICE_W:0] diff_ring [WINDOW_CAP];
        logic [31:0]             gain_sum;
        logic [31:0]             loss_acc;
        int unsigned             ring_ptr;
        int unsigned             ticks;
        int                      held;
        longint                  cash;
        t_trade_result           trade_q[$];
        int                      errors;

        function new();
            window_len = WIN_RESET;
            pos_limit  = LIM_RESET;
            sell_level = OB_RESET;
            buy_level  = OS_RESET;
            last_price = '0;
            gain_sum   = '0;
            loss_acc   = '0;
            ring_ptr   = 0;
            ticks      = 0;
            held       = 0;
            cash       = 0;
            errors     = 0;
        endfunction

        static function longint sat48(longint v);
            if (v > longint'(CASH_MAX)) return longint'(CASH_MAX);
            if (v < longint'(CASH_MIN)) return longint'(CASH_MIN);
            return v;
        endfunction

        function void configure(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WINDOW: begin
                    // restart the window, keep last price, position and cash
                    window_len = data[WIN_W-1:0];
                    gain_sum   = '0;
                    loss_acc   = '0;
                    ring_ptr   = 0;
                    if (ticks > 1) ticks = 1;
                end
                REG_LIMIT:      pos_limit  = data[LIM_W-1:0];
                REG_OVERBOUGHT: sell_level = data[LVL_W-1:0];
                REG_OVERSOLD:   buy_level  = data[LVL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_price(logic [PRICE_W-1:0] price);
            int unsigned   win;
            int unsigned   slot;
            longint        step;
            longint        oldest;
            longint        marked;
            longint unsigned total;
            longint unsigned scaled;
            t_trade_result want;
            win  = (window_len == 0) ? 1 :
                   ((window_len > WINDOW_CAP) ? WINDOW_CAP : int'(window_len));
            want = '{default: '0};
            if (ticks >= 1) begin
                // retire the oldest difference once the window is full, then add the new one
                step = longint'(price) - longint'(last_price);
                slot = (ring_ptr >= win) ? 0 : ring_ptr;
                if (ticks - 1 >= win) begin
                    oldest = diff_ring[slot];
                    if (oldest > 0) gain_sum -= 32'(oldest);
                    else if (oldest < 0) loss_acc -= 32'(-oldest);
                end
                diff_ring[slot] = step[PRICE_W:0];
                if (step > 0) gain_sum += 32'(step);
                else if (step < 0) loss_acc += 32'(-step);
                slot++;
                ring_ptr = (slot >= win) ? 0 : slot;
                if (ticks < win + 1) ticks++;
            end else begin
                ticks = 1;
            end
            last_price = price;

            total = 64'(gain_sum) + 64'(loss_acc);
            if (ticks >= win + 1 && total != 0) begin
                // thresholds compare the exact ratio, selling first
                scaled      = 64'(gain_sum) * 64'd10000;
                want.rsi_ok = 1'b1;
                want.rsi    = RSI_W'(scaled / total);
                if (scaled > 64'(sell_level) * total && held > -int'(pos_limit)) begin
                    want.action = ACT_SELL;
                    held--;
                    cash = sat48(cash + longint'(price));
                end else if (scaled < 64'(buy_level) * total && held < int'(pos_limit)) begin
                    want.action = ACT_BUY;
                    held++;
                    cash = sat48(cash - longint'(price));
                end
            end
            marked      = sat48(cash + longint'(held) * longint'(price));
            want.units  = held[UNITS_W-1:0];
            want.cash   = cash[CASH_W-1:0];
            want.marked = marked[CASH_W-1:0];
            trade_q.insert(trade_q.size(), want);
        endfunction

        function void compare_field(string name, logic signed [63:0] want_v,
                                    logic signed [63:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_trade_result got);
            t_trade_result want;
            if (trade_q.size() == 0) begin
                $error("result item arrived with nothing outstanding");
                errors++;
                return;
            end
            want = trade_q.pop_front();
            compare_field("rsi_hundredths", want.rsi, got.rsi);
            compare_field("rsi_valid", want.rsi_ok, got.rsi_ok);
            compare_field("action", want.action, got.action);
            compare_field("held_units", want.units, got.units);
            compare_field("cash_balance", want.cash, got.cash);
            compare_field("marked_value", want.marked, got.marked);
        endfunction

        function int outstanding();
            return trade_q.size();
        endfunction
    endclass

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data  = '0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    logic [PRICE_W-1:0]          i_price     = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [RSI_W-1:0]            o_rsi_hundredths;
    logic                        o_rsi_valid;
    logic [1:0]                  o_action;
    logic signed [UNITS_W-1:0]   o_held_units;
    logic signed [CASH_W-1:0]    o_cash_balance;
    logic signed [CASH_W-1:0]    o_marked_value;

    t_trade_scoreboard trades;
    int                results_seen = 0;
    int                ticks_sent   = 0;
    int                cur_price;
    int                trend;
    int                flat_left;
    bit                busy;

    rsi_threshold_trader u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_price          (i_price),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_rsi_hundredths (o_rsi_hundredths),
        .o_rsi_valid      (o_rsi_valid),
        .o_action         (o_action),
        .o_held_units     (o_held_units),
        .o_cash_balance   (o_cash_balance),
        .o_marked_value   (o_marked_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every result item taken by the sink
    always @(posedge i_clk) begin
        t_trade_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.rsi    = o_rsi_hundredths;
            got.rsi_ok = o_rsi_valid;
            got.action = o_action;
            got.units  = o_held_units;
            got.cash   = o_cash_balance;
            got.marked = o_marked_value;
            trades.check_result(got);
            results_seen++;
        end
    end

    // Result sink: random stall stretches, one long hold-off to back the block up
    initial begin : result_sink
        int span;
        int pick;
        bit stall_now;
        bit held_off;
        held_off = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                stall_now = ($urandom_range(0, 2) == 0);
                pick      = $urandom_range(0, 19);
                if (pick < 14) span = $urandom_range(1, 4);
                else if (pick < 19) span = $urandom_range(5, 12);
                else span = stall_now ? $urandom_range(20, 50) : $urandom_range(60, 150);
                i_out_stall <= stall_now;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // Random walk with trends, flat stretches and occasional jumps anywhere in range
    function automatic logic [PRICE_W-1:0] next_price();
        int pick;
        int mag;
        pick = $urandom_range(0, 31);
        if (flat_left > 0) begin
            flat_left--;
        end else if (pick == 0) begin
            cur_price = $urandom_range(0, PRICE_MAX);
        end else if (pick == 1) begin
            flat_left = $urandom_range(1, 24);
        end else if (pick > 3) begin
            if ($urandom_range(0, 15) == 0) trend = -trend;
            mag = $urandom_range(0, 1 << $urandom_range(0, 20));
            cur_price += ($urandom_range(0, 3) == 0) ? -trend * mag : trend * mag;
            if (cur_price < 0) cur_price = 0;
            if (cur_price > PRICE_MAX) cur_price = PRICE_MAX;
        end
        return cur_price[PRICE_W-1:0];
    endfunction

    task automatic put_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        trades.configure(idx, data);
    endtask

    task automatic write_settings(input logic [WIN_W-1:0] win, input logic [LIM_W-1:0] lim,
                                  input logic [LVL_W-1:0] ob, input logic [LVL_W-1:0] os);
        put_reg(REG_WINDOW, CFG_DATA_W'(win));
        put_reg(REG_LIMIT, CFG_DATA_W'(lim));
        put_reg(REG_OVERBOUGHT, CFG_DATA_W'(ob));
        put_reg(REG_OVERSOLD, CFG_DATA_W'(os));
        i_cfg_we <= 1'b0;
    endtask

    // Offer one price, hold it until taken, then idle for a random, possibly empty gap (always empty in busy mode)
    task automatic feed_price(input logic [PRICE_W-1:0] price);
        int gap;
        int pick;
        i_in_valid <= 1'b1;
        i_price    <= price;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        trades.note_price(price);
        ticks_sent++;
        pick = $urandom_range(0, 15);
        if (busy || pick < 8) gap = 0;
        else if (pick < 14) gap = $urandom_range(1, 3);
        else if (pick < 15) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every result item is back and the block is idle
    task automatic close_phase();
        i_in_valid <= 1'b0;
        while (trades.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] win, input logic [LIM_W-1:0] lim,
                             input logic [LVL_W-1:0] ob, input logic [LVL_W-1:0] os,
                             input int count);
        write_settings(win, lim, ob, os);
        busy = ($urandom_range(0, 3) == 0);
        repeat (count) feed_price(next_price());
        close_phase();
    endtask

    initial begin : stimulus
        logic [PRICE_W-1:0] swings [13];
        logic [PRICE_W-1:0] balanced [6];
        logic [PRICE_W-1:0] crossed [2];
        logic [WIN_W-1:0]   win;
        logic [LIM_W-1:0]   lim;
        logic [LVL_W-1:0]   ob;
        logic [LVL_W-1:0]   os;

        trades    = new();
        cur_price = $urandom_range(0, PRICE_MAX);
        trend     = 1;
        flat_left = 0;
        busy      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-difference window: first tick, flat tick, full swings, limits both ways
        swings = '{24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                   24'h000001, 24'h000000, 24'h555555, 24'hAAAAAA, 24'hCCCCCC, 24'hFFFFFE,
                   24'hFFFFFF};
        write_settings(9'd1, 8'd2, 14'd7000, 14'd3000);
        foreach (swings[k]) feed_price(swings[k]);
        close_phase();

        // RSI exactly on both levels: no trade
        balanced = '{24'd100, 24'd103, 24'd102, 24'd101, 24'd100, 24'd103};
        write_settings(9'd4, 8'd3, 14'd5000, 14'd5000);
        foreach (balanced[k]) feed_price(balanced[k]);
        close_phase();

        // Both levels met without restarting the window: sell wins
        crossed = '{24'd102, 24'd101};
        put_reg(REG_OVERBOUGHT, CFG_DATA_W'(14'd3000));
        put_reg(REG_OVERSOLD, CFG_DATA_W'(14'd7000));
        i_cfg_we <= 1'b0;
        foreach (crossed[k]) feed_price(crossed[k]);
        close_phase();

        // Extreme settings, then random ones
        run_phase(9'd0, 8'd0, 14'd0, 14'd10000, 120);
        run_phase(9'd3, 8'd255, 14'd16383, 14'd16383, 330);
        run_phase(9'd511, 8'd255, 14'd0, 14'd0, 300);
        run_phase(9'd256, 8'd255, 14'd10000, 14'd10001, 280);
        while (ticks_sent < RANDOM_TICKS) begin
            case ($urandom_range(0, 9))
                0:             win = WIN_W'($urandom_range(0, 1));
                1, 2, 3, 4, 5: win = WIN_W'($urandom_range(2, 16));
                default:       win = WIN_W'($urandom_range(17, 40));
            endcase
            case ($urandom_range(0, 7))
                0:       lim = 8'd0;
                1:       lim = 8'd255;
                default: lim = LIM_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       ob = LVL_W'($urandom_range(0, 16383));
                1:       ob = 14'd10000;
                default: ob = LVL_W'($urandom_range(5000, 9500));
            endcase
            case ($urandom_range(0, 7))
                0:       os = LVL_W'($urandom_range(0, 16383));
                1:       os = 14'd0;
                default: os = LVL_W'($urandom_range(500, 5000));
            endcase
            run_phase(win, lim, ob, os, int'(win) + $urandom_range(40, 140));
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (trades.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin : watchdog
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
